// ===== sv/tsrb_pkg.sv =====
package tsrb_pkg;

    // Field widths of the command and result ports
    localparam int ACT_W    = 3;
    localparam int TS_W     = 64;
    localparam int LEN_W    = 12;
    localparam int SMP_W    = 32;
    localparam int STATUS_W = 2;
    localparam int AVAIL_W  = 63;

    typedef enum logic [ACT_W-1:0] {
        ACT_WR_BLOCK  = 3'd0,
        ACT_WR_SAMPLE = 3'd1,
        ACT_RD_BLOCK  = 3'd2,
        ACT_RD_SAMPLE = 3'd3,
        ACT_CLEAR     = 3'd4,
        ACT_QUERY     = 3'd5
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK  = 2'd0,
        ST_TS  = 2'd1,
        ST_OVF = 2'd2
    } status_t;

endpackage

// ===== sv/timestamped_sample_ring_buffer.sv =====
// Channel   Ports                                            Direction  Handshake
// -------   -----------------------------------------------  ---------  ----------------------
// command   action, timestamp, block_length, sample_in       in         start && !busy
// result    status, sample_count, sample_out, available      out        done, one cycle, no stall
//
// One command is taken every clock; busy is always low. Each command gives exactly
// one result transfer, on done: the command passes the command register, then the
// update logic and the sample store read port into the result register. rst_n
// clears markers, pointers and the pipeline valids
// at once; the sample store is not cleared. The receiver cannot stall, so results
// never back up. BUF_LEN must be a power of two.
module timestamped_sample_ring_buffer
    import tsrb_pkg::*;
#(
    parameter int BUF_LEN = 4096
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [ACT_W-1:0]    action,
    input  logic [TS_W-1:0]     timestamp,
    input  logic [LEN_W-1:0]    block_length,
    input  logic [SMP_W-1:0]    sample_in,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [LEN_W-1:0]    sample_count,
    output logic [SMP_W-1:0]    sample_out,
    output logic [AVAIL_W-1:0]  available
);

    localparam int IDX_W = $clog2(BUF_LEN);
    localparam int EXT_W = TS_W + 1;   // one guard bit for exact signed sums

    // ---------------- command register ----------------
    logic                    in_vld_reg;
    action_t                 in_act_reg;
    logic signed [TS_W-1:0]  in_ts_reg;
    logic [LEN_W-1:0]        in_len_reg;
    logic [SMP_W-1:0]        in_smp_reg;

    // ---------------- ring markers and pointers ----------------
    logic signed [TS_W-1:0]  start_time_reg, start_time_next;
    logic signed [TS_W-1:0]  end_time_reg, end_time_next;
    logic [IDX_W-1:0]        start_idx_reg, start_idx_next;
    logic [IDX_W-1:0]        end_idx_reg, end_idx_next;
    logic [IDX_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0]        rd_ptr_reg, rd_ptr_next;

    // ---------------- result register ----------------
    logic                    done_reg;
    status_t                 status_reg, status_next;
    logic [LEN_W-1:0]        count_reg, count_next;
    logic [AVAIL_W-1:0]      avail_reg, avail_next;
    logic                    rd_sel_reg;
    logic [SMP_W-1:0]        sample_rd_reg;

    // Sample store: plain memory, contents undefined until written
    logic [SMP_W-1:0]        store_mem [BUF_LEN];

    // ---------------- datapath terms ----------------
    logic signed [EXT_W-1:0] ts65, len65, stop65, start65, end65;
    logic signed [EXT_W-1:0] off65, room65, diff65, new_start65;
    logic                    stop_ovf, len_bad;
    logic [IDX_W-1:0]        pos, pos_end;
    logic [31:0]             pos_len;
    logic                    wr_wrap, wr_init, wr_reject, rd_reject;
    logic [IDX_W-1:0]        wr_start_idx;
    logic signed [TS_W-1:0]  wr_start_time;

    assign busy = 1'b0;

    // Command register: one transfer per clock
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_act_reg <= action_t'(action);
            in_ts_reg  <= timestamp;
            in_len_reg <= block_length;
            in_smp_reg <= sample_in;
        end
    end

    // Exact 65-bit views of the times so no sum or difference can wrap
    assign ts65    = EXT_W'(in_ts_reg);
    assign len65   = $signed(EXT_W'(in_len_reg));
    assign start65 = EXT_W'(start_time_reg);
    assign end65   = EXT_W'(end_time_reg);
    assign stop65  = ts65 + len65;
    assign stop_ovf = stop65[TS_W] != stop65[TS_W-1];
    assign len_bad = 32'(in_len_reg) >= 32'(BUF_LEN);

    // Ring position: with a power-of-two ring the floor modulo is the low bits
    assign pos     = start_idx_reg + in_ts_reg[IDX_W-1:0] - start_time_reg[IDX_W-1:0];
    assign pos_len = 32'(pos) + 32'(in_len_reg);
    assign pos_end = pos_len[IDX_W-1:0];

    // Write block placement
    assign off65   = ts65 - start65;
    assign room65  = EXT_W'(BUF_LEN) - $signed(EXT_W'(start_idx_reg));
    assign wr_wrap = off65[TS_W] || (off65 >= room65) ||
                     ((in_len_reg != '0) && (pos_len >= 32'(BUF_LEN)));
    assign wr_init = (start_idx_reg == '0);
    assign wr_reject = len_bad || in_ts_reg[TS_W-1] || stop_ovf || (stop65 <= end65);
    assign wr_start_idx  = wr_init ? pos : start_idx_reg;
    assign wr_start_time = wr_init ? in_ts_reg : start_time_reg;
    assign new_start65   = EXT_W'(wr_start_time);

    // Read block must end between the markers
    assign rd_reject = len_bad || (stop65 > end65) || (stop65 < start65);

    // Query distance to end marker
    assign diff65 = end65 - ts65;

    always_comb
    begin
        start_time_next = start_time_reg;
        end_time_next   = end_time_reg;
        start_idx_next  = start_idx_reg;
        end_idx_next    = end_idx_reg;
        wr_ptr_next     = wr_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        status_next     = ST_OK;
        count_next      = '0;
        avail_next      = '0;
        if (in_vld_reg)
        begin
            case (in_act_reg)
                ACT_WR_BLOCK:
                begin
                    if (wr_reject)
                    begin
                        status_next = ST_TS;
                    end
                    else
                    begin
                        start_idx_next  = wr_start_idx;
                        start_time_next = wr_start_time;
                        end_idx_next    = pos_end;
                        end_time_next   = stop65[TS_W-1:0];
                        wr_ptr_next     = pos;
                        // overflow: a later block wrapped past the start marker
                        if (!wr_init && wr_wrap && (pos_end > wr_start_idx))
                        begin
                            status_next = ST_OVF;
                        end
                        else if (stop65 <= new_start65)
                        begin
                            status_next = ST_TS;
                        end
                        else
                        begin
                            count_next = in_len_reg;
                        end
                    end
                end
                ACT_WR_SAMPLE:
                begin
                    wr_ptr_next = wr_ptr_reg + 1'b1;
                end
                ACT_RD_BLOCK:
                begin
                    if (rd_reject)
                    begin
                        status_next = ST_TS;
                    end
                    else
                    begin
                        rd_ptr_next     = pos;
                        start_idx_next  = pos_end;
                        start_time_next = stop65[TS_W-1:0];
                        count_next      = in_len_reg;
                    end
                end
                ACT_RD_SAMPLE:
                begin
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                end
                ACT_CLEAR:
                begin
                    start_time_next = '0;
                    end_time_next   = '0;
                    start_idx_next  = '0;
                    end_idx_next    = '0;
                    wr_ptr_next     = '0;
                    rd_ptr_next     = '0;
                end
                ACT_QUERY:
                begin
                    // saturate at the largest 63-bit count
                    if (ts65 < end65)
                    begin
                        avail_next = diff65[TS_W-1] ? '1 : diff65[AVAIL_W-1:0];
                    end
                end
                default:
                begin
                    // undefined actions give an all-zero result
                end
            endcase
        end
    end

    // State and result control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_time_reg <= '0;
            end_time_reg   <= '0;
            start_idx_reg  <= '0;
            end_idx_reg    <= '0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            done_reg       <= 1'b0;
            rd_sel_reg     <= 1'b0;
        end
        else
        begin
            start_time_reg <= start_time_next;
            end_time_reg   <= end_time_next;
            start_idx_reg  <= start_idx_next;
            end_idx_reg    <= end_idx_next;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            done_reg       <= in_vld_reg;
            rd_sel_reg     <= in_vld_reg && (in_act_reg == ACT_RD_SAMPLE);
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        count_reg  <= count_next;
        avail_reg  <= avail_next;
    end

    // Sample store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (in_vld_reg && (in_act_reg == ACT_WR_SAMPLE))
        begin
            store_mem[wr_ptr_reg] <= in_smp_reg;
        end
        sample_rd_reg <= store_mem[rd_ptr_reg];
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign sample_count = count_reg;
    assign sample_out   = rd_sel_reg ? sample_rd_reg : '0;
    assign available    = avail_reg;

    // ---------------- assertions ----------------
    a_done_follows_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("command without result");

    a_no_stray_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without command");

    a_status_only_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && in_act_reg != ACT_WR_BLOCK && in_act_reg != ACT_RD_BLOCK)
        |=> (status == ST_OK && sample_count == '0))
        else $error("status or count on a sample command");

    a_wr_ptr_step: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && in_act_reg == ACT_WR_SAMPLE)
        |=> (wr_ptr_reg == $past(wr_ptr_reg) + 1'b1))
        else $error("write pointer did not advance");

endmodule
